FILE: design/krt_pkg.sv
// Package for the keyed record table: sizes, action and status codes, result kinds.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package krt_pkg;
   localparam int CAPACITY = 32;
   localparam int SLOT_W = 6;
   localparam int IDX_W = $clog2(CAPACITY);

   localparam logic [2:0] ACT_ENROLL = 3'd0;
   localparam logic [2:0] ACT_REM_PERSON = 3'd1;
   localparam logic [2:0] ACT_REM_TEMPLATE = 3'd2;
   localparam logic [2:0] ACT_CLEAR = 3'd3;
   localparam logic [2:0] ACT_FETCH = 3'd4;
   localparam logic [2:0] ACT_PERSIST = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic KIND_FINAL = 1'b0;
   localparam logic KIND_MOVE = 1'b1;

   localparam logic [6:0] CSR_RESET = 7'd30;
   localparam logic [6:0] PERCENT_FULL = 7'd100;

   // controller to datapath
   typedef struct packed {
      logic load;         // latch request, clear scan state
      logic scan_clear;   // restart scan at slot 0
      logic scan_step;    // examine current slot (find / remove pass)
      logic comp_clear;   // restart compaction pointers
      logic comp_step;    // examine current slot in compaction
      logic comp_done;    // commit compaction counts
      logic enroll_write; // write request into chosen slot
      logic pct_calc;     // register dead share products
      logic emit_final;   // present final result
   } krt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] action;
      logic scan_end;     // scan index reached entry_count
      logic found;        // a live match was seen
      logic full;         // entry_count at capacity
      logic comp_end;     // compaction index reached entry_count
      logic over_pct;     // dead share exceeds threshold
   } krt_sts_type;
endpackage
`default_nettype wire

FILE: design/krt_ctrl.sv
// Controller state machine for the keyed record table.
// Depends on krt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module krt_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   output krt_pkg::krt_cmd_type cmd,
   input  wire krt_pkg::krt_sts_type sts
);
   import krt_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_SCAN    = 8'b0000_0010,
      S_COMP    = 8'b0000_0100,
      S_RECHECK = 8'b0000_1000,
      S_WRITE   = 8'b0001_0000,
      S_PCT     = 8'b0010_0000,
      S_PCTCMP  = 8'b0100_0000,
      S_FINAL   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.action == ACT_PERSIST) begin
               state_in = S_PCT;
            end else if (sts.scan_end) begin
               if (sts.action == ACT_ENROLL) begin
                  if (!sts.found && sts.full) begin
                     cmd.comp_clear = 1'b1;
                     state_in = S_COMP;
                  end else begin
                     state_in = S_WRITE;
                  end
               end else begin
                  state_in = S_FINAL;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_COMP: begin
            if (sts.comp_end) begin
               cmd.comp_done = 1'b1;
               state_in = (sts.action == ACT_ENROLL) ? S_RECHECK : S_FINAL;
            end else begin
               cmd.comp_step = 1'b1;
            end
         end
         S_RECHECK: state_in = S_WRITE;
         S_WRITE: begin
            cmd.enroll_write = 1'b1;
            state_in = S_FINAL;
         end
         S_PCT: begin
            cmd.pct_calc = 1'b1;
            state_in = S_PCTCMP;
         end
         S_PCTCMP: begin
            if (sts.over_pct) begin
               cmd.comp_clear = 1'b1;
               state_in = S_COMP;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            cmd.emit_final = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_final |=> state_ff == S_IDLE) else $error("final not followed by idle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept did not raise busy");
endmodule
`default_nettype wire

FILE: design/krt_dp.sv
// Datapath for the keyed record table: record store, scan and compaction pointers,
// counts and result registers. Depends on krt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module krt_dp (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [2:0] req_action,
   input  wire logic [31:0] req_person_id,
   input  wire logic [15:0] req_template_index,
   input  wire logic [7:0] req_quality_in,
   input  wire logic [31:0] req_scale_in,
   input  wire logic csr_write_enable,
   input  wire logic [6:0] csr_write_data,
   input  wire krt_pkg::krt_cmd_type cmd,
   output krt_pkg::krt_sts_type sts,
   output logic rsp_valid,
   output logic rsp_kind,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_slot,
   output logic [5:0] rsp_from_slot,
   output logic [7:0] rsp_quality_out,
   output logic [31:0] rsp_scale_out,
   output logic [5:0] rsp_removed_count,
   output logic [5:0] rsp_used_count,
   output logic [5:0] rsp_live_total,
   output logic rsp_last
);
   import krt_pkg::*;

   logic [31:0] person_mem [CAPACITY];
   logic [15:0] template_mem [CAPACITY];
   logic [7:0] quality_mem [CAPACITY];
   logic [31:0] scale_mem [CAPACITY];
   logic [CAPACITY-1:0] live_ff;

   logic [2:0] action_ff;
   logic [31:0] pid_ff, sc_ff;
   logic [15:0] tix_ff;
   logic [7:0] q_ff;
   logic [6:0] pct_ff;
   logic [SLOT_W-1:0] entry_ff, live_cnt_ff;
   logic [SLOT_W-1:0] idx_ff, kept_ff, found_slot_ff, removed_ff;
   logic found_ff;
   logic [1:0] status_ff;
   logic [12:0] dead_x_ff, entry_x_ff;

   logic [IDX_W-1:0] idx_a, kept_a;
   logic key_hit, pid_hit, scan_end, comp_end;
   logic [SLOT_W-1:0] dead_w, wslot;

   assign idx_a = idx_ff[IDX_W-1:0];
   assign kept_a = kept_ff[IDX_W-1:0];
   assign scan_end = (idx_ff >= entry_ff);
   assign comp_end = scan_end;
   assign pid_hit = live_ff[idx_a] && (person_mem[idx_a] == pid_ff);
   assign key_hit = pid_hit && (template_mem[idx_a] == tix_ff);
   assign dead_w = (entry_ff >= live_cnt_ff) ? entry_ff - live_cnt_ff : '0;
   assign wslot = found_ff ? found_slot_ff : entry_ff;

   assign sts.action = action_ff;
   assign sts.scan_end = scan_end;
   assign sts.found = found_ff;
   assign sts.full = (entry_ff >= SLOT_W'(CAPACITY));
   assign sts.comp_end = comp_end;
   assign sts.over_pct = (dead_x_ff > entry_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff <= CSR_RESET;
      end else if (csr_write_enable) begin
         pct_ff <= csr_write_data;
      end
   end

   // request latch, scan and compaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         pid_ff <= req_person_id;
         tix_ff <= req_template_index;
         q_ff <= req_quality_in;
         sc_ff <= req_scale_in;
         removed_ff <= '0;
         found_ff <= 1'b0;
         found_slot_ff <= '0;
         status_ff <= ST_OK;
      end
      if (cmd.scan_clear || cmd.comp_clear) begin
         idx_ff <= '0;
         kept_ff <= '0;
      end
      if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         case (action_ff)
            ACT_ENROLL, ACT_FETCH: begin
               if (key_hit && !found_ff) begin
                  found_ff <= 1'b1;
                  found_slot_ff <= idx_ff;
                  idx_ff <= entry_ff;
               end
            end
            ACT_REM_TEMPLATE: begin
               if (key_hit) begin
                  found_ff <= 1'b1;
                  found_slot_ff <= idx_ff;
                  removed_ff <= SLOT_W'(1);
                  idx_ff <= entry_ff;
               end
            end
            ACT_REM_PERSON: begin
               if (pid_hit) begin
                  removed_ff <= removed_ff + 1'b1;
               end
            end
            ACT_CLEAR: begin
               if (live_ff[idx_a]) begin
                  removed_ff <= removed_ff + 1'b1;
               end
            end
            default: idx_ff <= entry_ff;
         endcase
      end
      if (cmd.comp_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (live_ff[idx_a]) begin
            kept_ff <= kept_ff + 1'b1;
         end
      end
      if (cmd.pct_calc) begin
         dead_x_ff <= 13'(dead_w) * 13'(PERCENT_FULL);
         entry_x_ff <= 13'(entry_ff) * 13'(pct_ff);
      end
      if (cmd.enroll_write && !found_ff && sts.full) begin
         status_ff <= ST_FULL;
      end
   end

   // record store
   always_ff @(posedge clock) begin
      if (cmd.comp_step && live_ff[idx_a] && (kept_ff != idx_ff)) begin
         person_mem[kept_a] <= person_mem[idx_a];
         template_mem[kept_a] <= template_mem[idx_a];
         quality_mem[kept_a] <= quality_mem[idx_a];
         scale_mem[kept_a] <= scale_mem[idx_a];
      end
      if (cmd.enroll_write && !(!found_ff && sts.full)) begin
         person_mem[wslot[IDX_W-1:0]] <= pid_ff;
         template_mem[wslot[IDX_W-1:0]] <= tix_ff;
         quality_mem[wslot[IDX_W-1:0]] <= q_ff;
         scale_mem[wslot[IDX_W-1:0]] <= sc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         if (cmd.scan_step) begin
            if ((action_ff == ACT_REM_TEMPLATE && key_hit)
                  || (action_ff == ACT_REM_PERSON && pid_hit)
                  || action_ff == ACT_CLEAR) begin
               live_ff[idx_a] <= 1'b0;
            end
         end
         if (cmd.comp_step && live_ff[idx_a] && (kept_ff != idx_ff)) begin
            live_ff[kept_a] <= 1'b1;
            live_ff[idx_a] <= 1'b0;
         end
         if (cmd.enroll_write && !(!found_ff && sts.full)) begin
            live_ff[wslot[IDX_W-1:0]] <= 1'b1;
         end
      end
   end

   // counts
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         live_cnt_ff <= '0;
      end else begin
         if (cmd.comp_done) begin
            entry_ff <= kept_ff;
            live_cnt_ff <= kept_ff;
         end else if (cmd.enroll_write && !found_ff && !sts.full) begin
            entry_ff <= entry_ff + 1'b1;
            live_cnt_ff <= live_cnt_ff + 1'b1;
         end else if (cmd.scan_step && action_ff == ACT_REM_TEMPLATE && key_hit) begin
            if (live_cnt_ff != '0) live_cnt_ff <= live_cnt_ff - 1'b1;
         end else if (cmd.scan_step && action_ff == ACT_REM_PERSON && pid_hit) begin
            if (live_cnt_ff != '0) live_cnt_ff <= live_cnt_ff - 1'b1;
         end else if (cmd.scan_step && action_ff == ACT_CLEAR) begin
            live_cnt_ff <= '0;
         end
      end
   end

   // appended slot is entry_count minus one after the write
   function automatic logic [SLOT_W-1:0] wslot_final(input logic f,
         input logic [SLOT_W-1:0] fs, input logic [SLOT_W-1:0] ec);
      return f ? fs : ec - 1'b1;
   endfunction

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (cmd.comp_step && live_ff[idx_a] && (kept_ff != idx_ff))
            || cmd.emit_final;
      end
      rsp_kind <= KIND_FINAL;
      rsp_status <= ST_OK;
      rsp_slot <= '0;
      rsp_from_slot <= '0;
      rsp_quality_out <= '0;
      rsp_scale_out <= '0;
      rsp_removed_count <= '0;
      rsp_used_count <= '0;
      rsp_live_total <= '0;
      rsp_last <= 1'b0;
      if (cmd.comp_step) begin
         rsp_kind <= KIND_MOVE;
         rsp_slot <= kept_ff;
         rsp_from_slot <= idx_ff;
      end
      if (cmd.emit_final) begin
         rsp_kind <= KIND_FINAL;
         rsp_last <= 1'b1;
         rsp_used_count <= entry_ff;
         rsp_live_total <= live_cnt_ff;
         rsp_removed_count <= removed_ff;
         case (action_ff)
            ACT_ENROLL: begin
               rsp_status <= status_ff;
               rsp_slot <= (status_ff == ST_FULL) ? '0 : wslot_final(found_ff,
                  found_slot_ff, entry_ff);
            end
            ACT_REM_PERSON: rsp_status <= (removed_ff != '0) ? ST_OK : ST_NOT_FOUND;
            ACT_REM_TEMPLATE: begin
               rsp_status <= found_ff ? ST_OK : ST_NOT_FOUND;
               rsp_slot <= found_ff ? found_slot_ff : '0;
            end
            ACT_FETCH: begin
               rsp_status <= found_ff ? ST_OK : ST_NOT_FOUND;
               if (found_ff) begin
                  rsp_slot <= found_slot_ff;
                  rsp_quality_out <= quality_mem[found_slot_ff[IDX_W-1:0]];
                  rsp_scale_out <= scale_mem[found_slot_ff[IDX_W-1:0]];
               end
            end
            default: rsp_status <= ST_OK;
         endcase
      end
   end

   a_counts: assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff <= entry_ff) else $error("live count above entry count");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      entry_ff <= SLOT_W'(CAPACITY)) else $error("entry count above capacity");
   a_move_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_MOVE) |-> rsp_slot < rsp_from_slot)
      else $error("move does not go down");
endmodule
`default_nettype wire

FILE: design/keyed_record_table_with_compaction_top.sv
// Keyed record table: enroll, remove, clear, fetch and persist check with compaction.
// Items other than persist walk the used slots in a scan, then a compaction pass may run;
// one item at a time, and busy is high for the whole item.
// Moves and the final item appear on rsp_valid for one cycle each; no stall.
// Synchronous active-high reset empties the table and loads the threshold 30.
`timescale 1ns / 1ps
`default_nettype none
module keyed_record_table_with_compaction_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [2:0] req_action,
   input  wire logic [31:0] req_person_id,
   input  wire logic [15:0] req_template_index,
   input  wire logic [7:0] req_quality_in,
   input  wire logic [31:0] req_scale_in,
   input  wire logic csr_write_enable,
   input  wire logic [6:0] csr_write_data,
   output logic rsp_valid,
   output logic rsp_kind,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_slot,
   output logic [5:0] rsp_from_slot,
   output logic [7:0] rsp_quality_out,
   output logic [31:0] rsp_scale_out,
   output logic [5:0] rsp_removed_count,
   output logic [5:0] rsp_used_count,
   output logic [5:0] rsp_live_total,
   output logic rsp_last
);
   import krt_pkg::*;

   krt_cmd_type cmd;
   krt_sts_type sts;

   krt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
   );

   krt_dp u_dp (
      .clock(clock), .reset(reset),
      .req_action(req_action), .req_person_id(req_person_id),
      .req_template_index(req_template_index), .req_quality_in(req_quality_in),
      .req_scale_in(req_scale_in),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_status(rsp_status),
      .rsp_slot(rsp_slot), .rsp_from_slot(rsp_from_slot),
      .rsp_quality_out(rsp_quality_out), .rsp_scale_out(rsp_scale_out),
      .rsp_removed_count(rsp_removed_count), .rsp_used_count(rsp_used_count),
      .rsp_live_total(rsp_live_total), .rsp_last(rsp_last)
   );
endmodule
`default_nettype wire

FILE: sim/tb_keyed_record_table_with_compaction_top.sv
// Testbench for the keyed record table: directed and random command items, results
// checked against a behavioral table model kept in the bench. Depends on krt_pkg.
`timescale 1ns / 1ps
module tb_keyed_record_table_with_compaction_top;
   import krt_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;

   typedef struct packed {
      logic       kind;
      logic [1:0] status;
      logic [5:0] slot;
      logic [5:0] from_slot;
      logic [7:0] quality;
      logic [31:0] scale;
      logic [5:0] removed;
      logic [5:0] used;
      logic [5:0] live;
      logic       last;
   } table_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_action = '0;
   logic [31:0] req_person_id = '0;
   logic [15:0] req_template_index = '0;
   logic [7:0] req_quality_in = '0;
   logic [31:0] req_scale_in = '0;
   logic csr_write_enable = 1'b0;
   logic [6:0] csr_write_data = '0;
   logic rsp_valid, rsp_kind, rsp_last;
   logic [1:0] rsp_status;
   logic [5:0] rsp_slot, rsp_from_slot, rsp_removed_count, rsp_used_count, rsp_live_total;
   logic [7:0] rsp_quality_out;
   logic [31:0] rsp_scale_out;

   logic [31:0] tbl_person [CAPACITY];
   logic [15:0] tbl_template [CAPACITY];
   logic [7:0] tbl_quality [CAPACITY];
   logic [31:0] tbl_scale [CAPACITY];
   logic tbl_live [CAPACITY];
   int tbl_used, tbl_live_cnt;
   int dead_percent;

   table_result_t pending_results[$];
   int error_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   logic [31:0] person_pool [8];

   keyed_record_table_with_compaction_top uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic table_result_t make_result(input logic kind, input logic [1:0] st,
         input int slot, input int from, input logic [7:0] q, input logic [31:0] sc,
         input int removed, input int used, input int live, input logic last);
      table_result_t r;
      r.kind = kind; r.status = st; r.slot = slot[5:0]; r.from_slot = from[5:0];
      r.quality = q; r.scale = sc; r.removed = removed[5:0]; r.used = used[5:0];
      r.live = live[5:0]; r.last = last;
      return r;
   endfunction

   task automatic compact_table();
      int kept;
      kept = 0;
      for (int i = 0; i < tbl_used; i++) begin
         if (tbl_live[i]) begin
            if (kept != i) begin
               tbl_person[kept] = tbl_person[i];
               tbl_template[kept] = tbl_template[i];
               tbl_quality[kept] = tbl_quality[i];
               tbl_scale[kept] = tbl_scale[i];
               tbl_live[kept] = 1'b1;
               pending_results.push_back(make_result(KIND_MOVE, ST_OK, kept, i, '0, '0,
                  0, 0, 0, 1'b0));
            end
            kept++;
         end
      end
      tbl_used = kept;
      tbl_live_cnt = kept;
   endtask

   function automatic int find_live(input logic [31:0] pid, input logic [15:0] tix);
      for (int i = 0; i < tbl_used; i++)
         if (tbl_live[i] && tbl_person[i] == pid && tbl_template[i] == tix) return i;
      return -1;
   endfunction

   task automatic predict_table(input logic [2:0] act, input logic [31:0] pid,
         input logic [15:0] tix, input logic [7:0] q, input logic [31:0] sc);
      logic [1:0] st;
      int slot, removed, f, dead;
      logic [7:0] rq;
      logic [31:0] rs;
      st = ST_OK; slot = 0; removed = 0; rq = '0; rs = '0;
      case (act)
         ACT_ENROLL: begin
            f = find_live(pid, tix);
            if (f < 0) begin
               if (tbl_used >= CAPACITY) compact_table();
               if (tbl_used >= CAPACITY) st = ST_FULL;
               else begin
                  f = tbl_used;
                  tbl_used++;
                  tbl_live_cnt++;
               end
            end
            if (st != ST_FULL) begin
               slot = f;
               tbl_person[f] = pid; tbl_template[f] = tix;
               tbl_quality[f] = q; tbl_scale[f] = sc; tbl_live[f] = 1'b1;
            end
         end
         ACT_REM_PERSON: begin
            for (int i = 0; i < tbl_used; i++)
               if (tbl_live[i] && tbl_person[i] == pid) begin
                  tbl_live[i] = 1'b0;
                  removed++;
               end
            tbl_live_cnt = (tbl_live_cnt >= removed) ? tbl_live_cnt - removed : 0;
            st = removed ? ST_OK : ST_NOT_FOUND;
         end
         ACT_REM_TEMPLATE: begin
            f = find_live(pid, tix);
            if (f < 0) st = ST_NOT_FOUND;
            else begin
               slot = f; tbl_live[f] = 1'b0; removed = 1;
               if (tbl_live_cnt > 0) tbl_live_cnt--;
            end
         end
         ACT_CLEAR: begin
            for (int i = 0; i < tbl_used; i++)
               if (tbl_live[i]) begin
                  tbl_live[i] = 1'b0;
                  removed++;
               end
            tbl_live_cnt = 0;
         end
         ACT_FETCH: begin
            f = find_live(pid, tix);
            if (f < 0) st = ST_NOT_FOUND;
            else begin
               slot = f; rq = tbl_quality[f]; rs = tbl_scale[f];
            end
         end
         ACT_PERSIST: begin
            dead = (tbl_used >= tbl_live_cnt) ? tbl_used - tbl_live_cnt : 0;
            if (dead * 100 > tbl_used * dead_percent) compact_table();
         end
         default: ;
      endcase
      pending_results.push_back(make_result(KIND_FINAL, st, slot, 0, rq, rs, removed,
         tbl_used, tbl_live_cnt, 1'b1));
   endtask

   // one item per handshake; bursts with random gaps
   task automatic send_item(input logic [2:0] act, input logic [31:0] pid,
         input logic [15:0] tix, input logic [7:0] q, input logic [31:0] sc);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      burst_left--;
      predict_table(act, pid, tix, q, sc);
      start <= 1'b1;
      req_action <= act; req_person_id <= pid; req_template_index <= tix;
      req_quality_in <= q; req_scale_in <= sc;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input int value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value[6:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dead_percent = value;
   endtask

   always @(posedge clock) begin
      table_result_t want, got;
      if (!reset && rsp_valid) begin
         got = {rsp_kind, rsp_status, rsp_slot, rsp_from_slot, rsp_quality_out,
            rsp_scale_out, rsp_removed_count, rsp_used_count, rsp_live_total, rsp_last};
         if (pending_results.size() == 0) report_mismatch("unexpected item", got.slot, 0);
         else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
            if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
            if (got.from_slot !== want.from_slot)
               report_mismatch("from_slot", got.from_slot, want.from_slot);
            if (got.quality !== want.quality)
               report_mismatch("quality", got.quality, want.quality);
            if (got.scale !== want.scale) report_mismatch("scale", got.scale, want.scale);
            if (got.removed !== want.removed)
               report_mismatch("removed", got.removed, want.removed);
            if (got.used !== want.used) report_mismatch("used", got.used, want.used);
            if (got.live !== want.live) report_mismatch("live", got.live, want.live);
            if (got.last !== want.last) report_mismatch("last", got.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_write_enable) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(ACT_FETCH, 32'h0, 16'h0, 8'h0, 32'h0);
      send_item(ACT_REM_PERSON, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      send_item(ACT_ENROLL, 32'h0, 16'h0, 8'h00, 32'h0);
      send_item(ACT_ENROLL, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      send_item(ACT_ENROLL, 32'hFFFF_FFFF, 16'hFFFF, 8'h5A, 32'hA5A5_5A5A);
      send_item(ACT_FETCH, 32'hFFFF_FFFF, 16'hFFFF, 8'h0, 32'h0);
      send_item(ACT_ENROLL, 32'hFFFF_FFFF, 16'h0001, 8'h11, 32'h1234_5678);
      send_item(ACT_REM_TEMPLATE, 32'hFFFF_FFFF, 16'hFFFF, 8'h0, 32'h0);
      send_item(ACT_REM_TEMPLATE, 32'hFFFF_FFFF, 16'hFFFF, 8'h0, 32'h0);
      send_item(ACT_PERSIST, 32'h0, 16'h0, 8'h0, 32'h0);
      send_item(ACT_REM_PERSON, 32'hFFFF_FFFF, 16'h0, 8'h0, 32'h0);
      send_item(3'd6, 32'h1, 16'h1, 8'h1, 32'h1);
      send_item(3'd7, 32'h2, 16'h2, 8'h2, 32'h2);
      send_item(ACT_CLEAR, 32'h0, 16'h0, 8'h0, 32'h0);
      send_item(ACT_PERSIST, 32'h0, 16'h0, 8'h0, 32'h0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i <= CAPACITY; i++)
         send_item(ACT_ENROLL, 32'h100 + i, i[15:0], i[7:0], $urandom);
      send_item(ACT_REM_TEMPLATE, 32'h100 + 3, 16'd3, 8'h0, 32'h0);
      send_item(ACT_REM_TEMPLATE, 32'h100 + 20, 16'd20, 8'h0, 32'h0);
      send_item(ACT_ENROLL, 32'h200, 16'd7, 8'h77, 32'h7777_7777);
      send_item(ACT_FETCH, 32'h100 + 31, 16'd31, 8'h0, 32'h0);
      wait_drained();
      send_item(ACT_CLEAR, 32'h0, 16'h0, 8'h0, 32'h0);
      send_item(ACT_PERSIST, 32'h0, 16'h0, 8'h0, 32'h0);
   endtask

   task automatic test_random(input int count);
      logic [2:0] act;
      logic [31:0] pid;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) act = ACT_ENROLL;
         else if (pick < 55) act = ACT_REM_PERSON;
         else if (pick < 72) act = ACT_REM_TEMPLATE;
         else if (pick < 75) act = ACT_CLEAR;
         else if (pick < 88) act = ACT_FETCH;
         else if (pick < 98) act = ACT_PERSIST;
         else act = 3'($urandom_range(6, 7));
         pid = ($urandom_range(0, 9) == 0) ? $urandom : person_pool[$urandom_range(0, 7)];
         send_item(act, pid, 16'($urandom_range(0, 5)) ^ (($urandom_range(0, 15) == 0)
            ? 16'($urandom) : 16'h0), 8'($urandom), $urandom);
      end
   endtask

   initial begin
      dead_percent = CSR_RESET;
      tbl_used = 0;
      tbl_live_cnt = 0;
      for (int i = 0; i < 8; i++) person_pool[i] = $urandom;
      person_pool[0] = 32'h0;
      person_pool[1] = 32'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      write_threshold(0);
      test_random(60);
      write_threshold(127);
      test_random(52);
      write_threshold(100);
      test_random(52);
      write_threshold($urandom_range(1, 99));
      test_random(52);
      wait_drained();
      if (error_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
